// ----- rtl/tpd_pkg.sv -----
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types, sizes and ring pointer helpers for the threshold priority deque.
// ----------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

  localparam int DEPTH    = 64;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 8;
  localparam int OCC_W    = 7;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NO_BED   = 3'd4
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_status_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) begin
      r = PTR_W'(DEPTH - 1);
    end else begin
      r = p - PTR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tpd_if.sv -----
// ----------------------------------------------------------------------------
// tpd_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpd_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] patient_id;
  logic [7:0]  patient_priority;
  logic        bed_free;

  modport source (output valid, cmd, patient_id, patient_priority, bed_free, input ready);
  modport sink   (input valid, cmd, patient_id, patient_priority, bed_free, output ready);
endinterface

interface tpd_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_id;
  logic [7:0]  out_priority;
  logic [6:0]  occupancy;

  modport source (output valid, status, out_id, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_id, out_priority, occupancy, output ready);
endinterface

`default_nettype wire

// ----- rtl/tpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpd_ctrl
// Two-state controller: take a word, then execute it once the result slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire tpd_pkg::dp_status_t dp_status,
  output tpd_pkg::ctrl_cmd_t      ctrl_cmd
);

  tpd_pkg::state_t state;
  tpd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    req_ready        = 1'b0;
    ctrl_cmd.capture = 1'b0;
    ctrl_cmd.exec    = 1'b0;
    case (state)
      tpd_pkg::S_IDLE: begin
        req_ready        = 1'b1;
        ctrl_cmd.capture = req_valid;
        if (req_valid) begin
          state_next = tpd_pkg::S_EXEC;
        end
      end
      tpd_pkg::S_EXEC: begin
        if (!dp_status.out_stall) begin
          ctrl_cmd.exec = 1'b1;
          state_next    = tpd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tpd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tpd_datapath.sv -----
// ----------------------------------------------------------------------------
// tpd_datapath
// Entry memory, ring pointers, count, threshold register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tpd_pkg::ctrl_cmd_t ctrl_cmd,
  output tpd_pkg::dp_status_t     dp_status,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               in_cmd,
  input  wire logic [15:0]        in_id,
  input  wire logic [7:0]         in_prio,
  input  wire logic               in_bed,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic [15:0]             out_id,
  output logic [7:0]              out_prio,
  output logic [6:0]              out_occ
);

  tpd_pkg::entry_t mem [tpd_pkg::DEPTH];

  logic [tpd_pkg::PTR_W-1:0]  head;
  logic [tpd_pkg::PTR_W-1:0]  tail;
  logic [tpd_pkg::CNT_W-1:0]  count;
  logic [tpd_pkg::PRIO_W-1:0] threshold;

  logic                       cmd_q;
  tpd_pkg::entry_t            item_q;
  logic                       bed_q;
  tpd_pkg::entry_t            rd_head;
  tpd_pkg::entry_t            rd_back;

  logic [tpd_pkg::PTR_W-1:0]  back_addr;
  logic [tpd_pkg::PTR_W-1:0]  head_next;
  logic [tpd_pkg::PTR_W-1:0]  tail_next;
  logic [tpd_pkg::CNT_W-1:0]  count_next;
  logic                       wr_en;
  logic [tpd_pkg::PTR_W-1:0]  wr_addr;
  tpd_pkg::status_t           status_next;
  tpd_pkg::entry_t            res_next;

  assign back_addr           = tpd_pkg::ptr_prev(tail);
  assign dp_status.out_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item_q;
    end
    rd_head <= mem[head];
    rd_back <= mem[back_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.capture) begin
      cmd_q       <= in_cmd;
      item_q.id   <= in_id;
      item_q.prio <= in_prio;
      bed_q       <= in_bed;
    end
  end

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    wr_en       = 1'b0;
    wr_addr     = tail;
    status_next = tpd_pkg::ST_INSERTED;
    res_next    = '0;
    if (cmd_q == tpd_pkg::CMD_INSERT) begin
      if (count == tpd_pkg::CNT_W'(tpd_pkg::DEPTH)) begin
        status_next = tpd_pkg::ST_FULL;
      end else begin
        wr_en      = ctrl_cmd.exec;
        count_next = count + tpd_pkg::CNT_W'(1);
        if (item_q.prio >= threshold) begin
          head_next = tpd_pkg::ptr_prev(head);
          wr_addr   = head_next;
        end else begin
          tail_next = tpd_pkg::ptr_next(tail);
        end
      end
    end else if (count == '0) begin
      status_next = tpd_pkg::ST_EMPTY;
    end else if (!bed_q) begin
      status_next = tpd_pkg::ST_NO_BED;
    end else begin
      status_next = tpd_pkg::ST_REMOVED;
      count_next  = count - tpd_pkg::CNT_W'(1);
      if (rd_head.prio >= rd_back.prio) begin
        res_next  = rd_head;
        head_next = tpd_pkg::ptr_next(head);
      end else begin
        res_next  = rd_back;
        tail_next = back_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      threshold <= 8'd128;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (ctrl_cmd.exec) begin
        head      <= head_next;
        tail      <= tail_next;
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.exec) begin
      out_status <= status_next;
      out_id     <= res_next.id;
      out_prio   <= res_next.prio;
      out_occ    <= tpd_pkg::OCC_W'(count_next);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/threshold_priority_deque.sv -----
// ----------------------------------------------------------------------------
// threshold_priority_deque
// Ring deque that inserts urgent words at the front and removes the larger end.
// A request word is registered, then its result in execute once the result slot is free.
// No new word is taken until the last is through (memory read, then compare and update).
// A stalled result holds the controller in execute until the word is taken.
// Reset: pointers, count and result valid clear; threshold loads 128.
// The entry memory is not cleared; only occupied slots ever reach a result.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_priority_deque (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  tpd_req_if.sink         req,
  tpd_rsp_if.source       rsp
);

  tpd_pkg::ctrl_cmd_t  ctrl_cmd;
  tpd_pkg::dp_status_t dp_status;

  tpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .dp_status (dp_status),
    .ctrl_cmd  (ctrl_cmd)
  );

  tpd_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl_cmd   (ctrl_cmd),
    .dp_status  (dp_status),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_cmd     (req.cmd),
    .in_id      (req.patient_id),
    .in_prio    (req.patient_priority),
    .in_bed     (req.bed_free),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_id     (rsp.out_id),
    .out_prio   (rsp.out_priority),
    .out_occ    (rsp.occupancy)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while previous word in progress");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == tpd_pkg::ST_EMPTY |-> rsp.occupancy == '0)
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == tpd_pkg::ST_FULL |->
      rsp.occupancy == tpd_pkg::OCC_W'(tpd_pkg::DEPTH))
    else $error("full status with occupancy below depth");

endmodule

`default_nettype wire

// ----- tb/sv/tpd_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// tpd_tb_pkg
// Scoreboard for the threshold priority deque. It keeps its own copy of the
// ring, the pointers, the count and the threshold. It works out the result of
// every request word taken by the block and matches the result words against
// those outcomes in order.
// ----------------------------------------------------------------------------
package tpd_tb_pkg;

  import tpd_pkg::*;

  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              bed_free;
  } ward_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   prio;
    logic [OCC_W-1:0]    occupancy;
  } ward_result_t;

  localparam int REPORT_LIMIT = 10;

  class triage_scoreboard;
    entry_t            ward [DEPTH];
    int unsigned       front_slot;
    int unsigned       after_back_slot;
    int unsigned       held;
    logic [PRIO_W-1:0] threshold;
    ward_result_t      awaited_outcomes [$];
    int unsigned       failures;

    function new();
      front_slot      = 0;
      after_back_slot = 0;
      held            = 0;
      threshold       = 8'd128;
      failures        = 0;
    endfunction

    function void set_threshold(logic [PRIO_W-1:0] value);
      threshold = value;
    endfunction

    function int unsigned pending();
      return awaited_outcomes.size();
    endfunction

    function ward_result_t triage_step(ward_request_t r);
      ward_result_t res;
      int unsigned  back_slot;
      res = '0;
      if (r.cmd == CMD_INSERT) begin
        if (held >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (r.prio >= threshold) begin
            front_slot = (front_slot + DEPTH - 1) % DEPTH;
            ward[front_slot] = {r.id, r.prio};
          end else begin
            ward[after_back_slot] = {r.id, r.prio};
            after_back_slot = (after_back_slot + 1) % DEPTH;
          end
          held++;
          res.status = ST_INSERTED;
        end
      end else if (held == 0) begin
        res.status = ST_EMPTY;
      end else if (!r.bed_free) begin
        res.status = ST_NO_BED;
      end else begin
        back_slot = (after_back_slot + DEPTH - 1) % DEPTH;
        if (ward[front_slot].prio >= ward[back_slot].prio) begin
          res.id   = ward[front_slot].id;
          res.prio = ward[front_slot].prio;
          front_slot = (front_slot + 1) % DEPTH;
        end else begin
          res.id   = ward[back_slot].id;
          res.prio = ward[back_slot].prio;
          after_back_slot = back_slot;
        end
        held--;
        res.status = ST_REMOVED;
      end
      res.occupancy = OCC_W'(held);
      return res;
    endfunction

    function void report(string what, ward_result_t exp, ward_result_t got);
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("[%0t] %s: expected status %0d id %h prio %h occ %0d, got status %0d id %h prio %h occ %0d",
                 $time, what, exp.status, exp.id, exp.prio, exp.occupancy,
                 got.status, got.id, got.prio, got.occupancy);
      end
    endfunction

    function void note_request(ward_request_t r);
      awaited_outcomes.push_back(triage_step(r));
    endfunction

    function void check_result(ward_result_t got);
      ward_result_t exp;
      if (awaited_outcomes.size() == 0) begin
        report("unexpected result word", '0, got);
      end else begin
        exp = awaited_outcomes.pop_front();
        if (got.status !== exp.status || got.id !== exp.id || got.prio !== exp.prio ||
            got.occupancy !== exp.occupancy) begin
          report("result mismatch", exp, got);
        end
      end
    endfunction

    function void check_drained();
      while (awaited_outcomes.size() != 0) begin
        report("missing result word", awaited_outcomes.pop_front(), '0);
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Regression for threshold_priority_deque. A directed run covers the empty,
// no-bed, single-entry, front/back choice and threshold edge cases, then
// random phases fill the deque past full and drain it past empty under
// several thresholds, with bursty request traffic and stalling result flow.
// ----------------------------------------------------------------------------
module tb_top;

  import tpd_pkg::*;
  import tpd_tb_pkg::*;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_RHYTHM
  } rx_pattern_t;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 104;

  localparam int THR_PLAN    [PHASES] = '{255, 0, 128, 1, 254, -1, 200, 128};
  localparam int INSERT_PLAN [PHASES] = '{85, 20, 55, 90, 10, 60, 80, 25};
  localparam int BED_PLAN    [PHASES] = '{90, 70, 95, 80, 90, 50, 85, 90};
  localparam int GAP_PLAN    [PHASES] = '{0, 6, 12, 3, 0, 10, 4, 8};

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  tpd_req_if req_ch ();
  tpd_rsp_if rsp_ch ();

  triage_scoreboard board;
  rx_pattern_t      rx_plan [PHASES] = '{RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM,
                                         RX_COIN, RX_OPEN, RX_SPARSE, RX_RHYTHM};
  rx_pattern_t      rx_mode = RX_OPEN;
  int unsigned      rx_tick = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      burst_left = 0;
  int unsigned      gap_max = 0;

  threshold_priority_deque dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   rsp_ch.ready <= 1'b1;
      RX_COIN:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   rsp_ch.ready <= ((rx_tick % 7) < 4);
    endcase
  end

  always @(posedge clk) begin
    if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
      board.note_request('{cmd: cmd_t'(req_ch.cmd), id: req_ch.patient_id,
                           prio: req_ch.patient_priority, bed_free: req_ch.bed_free});
    end
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      board.check_result('{status: rsp_ch.status, id: rsp_ch.out_id,
                           prio: rsp_ch.out_priority, occupancy: rsp_ch.occupancy});
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("threshold_priority_deque regression: fail");
      $finish;
    end
  end

  function automatic ward_request_t admission(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
    return '{cmd: CMD_INSERT, id: id, prio: prio, bed_free: 1'b0};
  endfunction

  function automatic ward_request_t discharge(logic bed);
    return '{cmd: CMD_REMOVE, id: ID_W'($urandom), prio: PRIO_W'($urandom), bed_free: bed};
  endfunction

  function automatic ward_request_t random_request(int insert_pct, int bed_pct);
    ward_request_t r;
    r.cmd      = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
    r.id       = ID_W'($urandom);
    r.bed_free = ($urandom_range(0, 99) < bed_pct);
    case ($urandom_range(0, 7))
      0:       r.prio = board.threshold;
      1:       r.prio = board.threshold - 8'd1;
      2:       r.prio = 8'h00;
      3:       r.prio = 8'hFF;
      default: r.prio = PRIO_W'($urandom);
    endcase
    return r;
  endfunction

  task automatic send_request(ward_request_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid            <= 1'b1;
    req_ch.cmd              <= r.cmd;
    req_ch.patient_id       <= r.id;
    req_ch.patient_priority <= r.prio;
    req_ch.bed_free         <= r.bed_free;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_threshold(value);
  endtask

  initial begin
    int p;
    board = new();
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_INSERT;
    req_ch.patient_id = '0;
    req_ch.patient_priority = '0;
    req_ch.bed_free = 1'b0;
    rsp_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset threshold of 128
    send_request(discharge(1'b1));
    send_request(discharge(1'b0));
    send_request(admission(16'h0000, 8'h00));
    send_request(discharge(1'b0));
    send_request(discharge(1'b1));
    send_request(admission(16'hFFFF, 8'hFF));
    send_request(admission(16'h0001, 8'd127));
    send_request(admission(16'h0002, 8'd128));
    send_request(discharge(1'b1));
    send_request(discharge(1'b1));
    send_request(discharge(1'b1));
    send_request(admission(16'h1234, 8'd10));
    send_request(admission(16'h4321, 8'd100));
    send_request(discharge(1'b1));
    send_request(discharge(1'b1));
    send_request(admission(16'h0F0F, 8'd50));
    send_request(admission(16'hF0F0, 8'd50));
    send_request(discharge(1'b1));
    send_request(discharge(1'b1));

    hold_until_drained();
    write_threshold(8'h00);
    send_request(admission(16'hAAAA, 8'h00));
    send_request(admission(16'h5555, 8'h00));
    send_request(discharge(1'b1));
    send_request(discharge(1'b1));

    hold_until_drained();
    write_threshold(8'hFF);
    send_request(admission(16'h8001, 8'hFE));
    send_request(admission(16'h7FFE, 8'hFF));

    for (p = 0; p < PHASES; p++) begin
      hold_until_drained();
      if (THR_PLAN[p] < 0) begin
        write_threshold(8'($urandom_range(0, 255)));
      end else begin
        write_threshold(8'(THR_PLAN[p]));
      end
      rx_mode = rx_plan[p];
      gap_max = GAP_PLAN[p];
      repeat (PHASE_WORDS) send_request(random_request(INSERT_PLAN[p], BED_PLAN[p]));
    end

    hold_until_drained();
    repeat (10) @(posedge clk);
    board.check_drained();
    if (board.failures == 0) begin
      $display("threshold_priority_deque regression: pass");
    end else begin
      $display("threshold_priority_deque regression: fail");
    end
    $finish;
  end

endmodule
